### hdl/cdau_pkg.sv
package cdau_pkg;

    localparam int COMPONENT_BITS_DEF   = 16;
    localparam int UV_FRACTION_BITS_DEF = 16;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // per-face: component and sign for u and v, atlas column and row
    typedef struct packed {
        axis_t      u_axis;
        logic       u_neg;
        axis_t      v_axis;
        logic       v_neg;
        logic [1:0] col;
        logic       row;
    } rule_t;

    // control that travels with each beat down the cell chain
    typedef struct packed {
        logic  valid;
        face_t face;
        logic  vres;
    } ctrl_t;

    localparam ctrl_t CTRL_IDLE = '{valid: 1'b0, face: FACE_POS_X, vres: 1'b0};

    function automatic rule_t face_rule(input face_t f);
        rule_t r;
        unique case (f)
            FACE_POS_X: r = '{u_axis: AXIS_Z, u_neg: 1'b0, v_axis: AXIS_Y, v_neg: 1'b1,
                              col: 2'd1, row: 1'b0};
            FACE_NEG_X: r = '{u_axis: AXIS_Z, u_neg: 1'b1, v_axis: AXIS_Y, v_neg: 1'b1,
                              col: 2'd0, row: 1'b0};
            FACE_POS_Y: r = '{u_axis: AXIS_X, u_neg: 1'b1, v_axis: AXIS_Z, v_neg: 1'b0,
                              col: 2'd2, row: 1'b0};
            FACE_NEG_Y: r = '{u_axis: AXIS_X, u_neg: 1'b1, v_axis: AXIS_Z, v_neg: 1'b1,
                              col: 2'd0, row: 1'b1};
            FACE_POS_Z: r = '{u_axis: AXIS_X, u_neg: 1'b1, v_axis: AXIS_Y, v_neg: 1'b1,
                              col: 2'd1, row: 1'b1};
            FACE_NEG_Z: r = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_Y, v_neg: 1'b1,
                              col: 2'd2, row: 1'b1};
            default:    r = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_X, v_neg: 1'b0,
                              col: 2'd0, row: 1'b0};
        endcase
        return r;
    endfunction

endpackage

### hdl/cube_direction_to_atlas_uv_unit.sv
// Cube-map direction to 3x2 atlas coordinate.
//
// Input channel (s_valid/s_ready): one beat carries a signed direction
// s_dir_x/y/z. Result channel (m_valid/m_ready): one beat per input beat,
// in order, with m_atlas_u/m_atlas_v (unsigned fractions, 2^UV_FRACTION_BITS
// is 1.0), m_face (0 +X, 1 -X, 2 +Y, 3 -Y, 4 +Z, 5 -Z) and m_valid_res, which
// is 0 for the zero vector; the other fields are then 0.
//
// Pipeline: one front stage (magnitude, face pick, numerators), one cell per
// quotient bit of the two restoring dividers (UV_FRACTION_BITS + 2 cells),
// and the rounding/output register. Throughput: one beat per cycle while
// m_ready does not stall the chain.
//
// Every stage holds its beat until the next stage has room, so a stall on
// m_ready fills bubbles upstream first; s_ready drops only when the whole
// chain is full. Reset (aresetn low, synchronous) empties the chain; no
// results are pending afterwards.
module cube_direction_to_atlas_uv_unit
    import cdau_pkg::*;
#(
    parameter int COMPONENT_BITS   = COMPONENT_BITS_DEF,
    parameter int UV_FRACTION_BITS = UV_FRACTION_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COMPONENT_BITS-1:0] s_dir_x,
    input  logic [COMPONENT_BITS-1:0] s_dir_y,
    input  logic [COMPONENT_BITS-1:0] s_dir_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [UV_FRACTION_BITS:0] m_atlas_u,
    output logic [UV_FRACTION_BITS:0] m_atlas_v,
    output logic [2:0]                m_face,
    output logic                      m_valid_res
);

    // denominators are 6m and 4m, m <= 2^(COMPONENT_BITS-1)
    localparam int DW    = COMPONENT_BITS + 2;
    localparam int RW    = DW + 1;
    localparam int QW    = UV_FRACTION_BITS + 2;
    localparam int NCELL = QW;
    localparam logic [UV_FRACTION_BITS:0] UV_HALF = (UV_FRACTION_BITS + 1)'(1)
                                                    << (UV_FRACTION_BITS - 1);
    localparam logic [UV_FRACTION_BITS:0] UV_ONE  = (UV_FRACTION_BITS + 1)'(1)
                                                    << UV_FRACTION_BITS;

    // chain links: index 0 is the front stage output, NCELL the last cell
    ctrl_t         ctrl_c  [NCELL+1];
    logic          ready_c [NCELL+1];
    logic [RW-1:0] ru_c    [NCELL+1];
    logic [RW-1:0] rv_c    [NCELL+1];
    logic [DW-1:0] du_c    [NCELL+1];
    logic [DW-1:0] dv_c    [NCELL+1];
    logic [QW-1:0] qu_c    [NCELL+1];
    logic [QW-1:0] qv_c    [NCELL+1];
    face_t         face_out;

    cdau_front #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .DW            (DW),
        .RW            (RW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (s_valid),
        .ready_o (s_ready),
        .dir_x_i (s_dir_x),
        .dir_y_i (s_dir_y),
        .dir_z_i (s_dir_z),
        .ready_i (ready_c[0]),
        .ctrl_o  (ctrl_c[0]),
        .ru_o    (ru_c[0]),
        .rv_o    (rv_c[0]),
        .du_o    (du_c[0]),
        .dv_o    (dv_c[0])
    );

    assign qu_c[0] = '0;
    assign qv_c[0] = '0;

    // one cell per quotient bit, MSB first
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        cdau_cell #(
            .DW(DW),
            .RW(RW),
            .QW(QW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (ctrl_c[i]),
            .ready_o (ready_c[i]),
            .ru_i    (ru_c[i]),
            .rv_i    (rv_c[i]),
            .du_i    (du_c[i]),
            .dv_i    (dv_c[i]),
            .qu_i    (qu_c[i]),
            .qv_i    (qv_c[i]),
            .ctrl_o  (ctrl_c[i+1]),
            .ready_i (ready_c[i+1]),
            .ru_o    (ru_c[i+1]),
            .rv_o    (rv_c[i+1]),
            .du_o    (du_c[i+1]),
            .dv_o    (dv_c[i+1]),
            .qu_o    (qu_c[i+1]),
            .qv_o    (qv_c[i+1])
        );
    end

    // final remainders and divisors are spent; only the quotients go on
    cdau_out #(
        .UV_FRACTION_BITS(UV_FRACTION_BITS),
        .QW              (QW)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_i    (ctrl_c[NCELL]),
        .ready_o   (ready_c[NCELL]),
        .qu_i      (qu_c[NCELL]),
        .qv_i      (qv_c[NCELL]),
        .ready_i   (m_ready),
        .valid_o   (m_valid),
        .atlas_u_o (m_atlas_u),
        .atlas_v_o (m_atlas_v),
        .face_o    (face_out),
        .vres_o    (m_valid_res)
    );

    assign m_face = face_out;

`ifndef ASSERT_OFF
    // reset empties the whole chain
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // zero vector yields all-zero fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |->
            (m_atlas_u == '0 && m_atlas_v == '0 && face_out == FACE_POS_X))
        else $error("zero vector with nonzero result fields");

    // coordinates never exceed 1.0
    a_uv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_atlas_u <= UV_ONE && m_atlas_v <= UV_ONE))
        else $error("atlas coordinate above 1.0");

    // top row faces land in the upper half of v, bottom row in the lower half
    a_row_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res && (face_out == FACE_POS_X || face_out == FACE_NEG_X ||
                                    face_out == FACE_POS_Y)) |-> (m_atlas_v >= UV_HALF))
        else $error("top-row face with v below one half");

    a_row_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res && (face_out == FACE_NEG_Y || face_out == FACE_POS_Z ||
                                    face_out == FACE_NEG_Z)) |-> (m_atlas_v <= UV_HALF))
        else $error("bottom-row face with v above one half");
`endif

endmodule

### hdl/cdau_front.sv
module cdau_front
    import cdau_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int DW             = COMPONENT_BITS_DEF + 2,
    parameter int RW             = COMPONENT_BITS_DEF + 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      valid_i,
    output logic                      ready_o,
    input  logic [COMPONENT_BITS-1:0] dir_x_i,
    input  logic [COMPONENT_BITS-1:0] dir_y_i,
    input  logic [COMPONENT_BITS-1:0] dir_z_i,
    input  logic                      ready_i,
    output ctrl_t                     ctrl_o,
    output logic [RW-1:0]             ru_o,
    output logic [RW-1:0]             rv_o,
    output logic [DW-1:0]             du_o,
    output logic [DW-1:0]             dv_o
);

    localparam int CW = COMPONENT_BITS;

    logic [CW-1:0]        mag_x, mag_y, mag_z, mag_m;
    axis_t                axis;
    logic                 neg;
    face_t                face;
    rule_t                rule;
    logic signed [CW-1:0] comp_u, comp_v;
    logic signed [DW-1:0] m_s, nu_s, nv_s;
    logic [DW-1:0]        two_m, four_m, un, vn;
    logic                 nonzero;

    ctrl_t         ctrl_reg, ctrl_next;
    logic [RW-1:0] ru_reg, rv_reg;
    logic [DW-1:0] du_reg, dv_reg;

    function automatic logic [CW-1:0] abs_val(input logic [CW-1:0] c);
        return c[CW-1] ? (~c + CW'(1)) : c;
    endfunction

    function automatic logic signed [CW-1:0] pick(input axis_t a,
                                                  input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [CW-1:0] z);
        logic [CW-1:0] r;
        unique case (a)
            AXIS_X:  r = x;
            AXIS_Y:  r = y;
            AXIS_Z:  r = z;
            default: r = x;
        endcase
        return signed'(r);
    endfunction

    always_comb begin
        mag_x   = abs_val(dir_x_i);
        mag_y   = abs_val(dir_y_i);
        mag_z   = abs_val(dir_z_i);
        nonzero = (dir_x_i != '0) || (dir_y_i != '0) || (dir_z_i != '0);

        // ties: X over Y over Z
        if (mag_x >= mag_y && mag_x >= mag_z) begin
            axis = AXIS_X;
        end else if (mag_y >= mag_z) begin
            axis = AXIS_Y;
        end else begin
            axis = AXIS_Z;
        end
        mag_m = (axis == AXIS_X) ? mag_x : ((axis == AXIS_Y) ? mag_y : mag_z);
        neg   = pick(axis, dir_x_i, dir_y_i, dir_z_i) < 0;
        face  = face_t'({axis, neg});
        rule  = face_rule(face);

        comp_u = pick(rule.u_axis, dir_x_i, dir_y_i, dir_z_i);
        comp_v = pick(rule.v_axis, dir_x_i, dir_y_i, dir_z_i);
        m_s    = signed'(DW'(mag_m));
        nu_s   = rule.u_neg ? (m_s - DW'(comp_u)) : (m_s + DW'(comp_u));
        nv_s   = rule.v_neg ? (m_s - DW'(comp_v)) : (m_s + DW'(comp_v));

        two_m  = {1'b0, mag_m, 1'b0};
        four_m = {mag_m, 2'b00};

        case (rule.col)
            2'd1:    un = unsigned'(nu_s) + two_m;
            2'd2:    un = unsigned'(nu_s) + four_m;
            default: un = unsigned'(nu_s);
        endcase
        vn = four_m - unsigned'(nv_s) - (rule.row ? two_m : '0);

        ctrl_next = '{valid: valid_i, face: nonzero ? face : FACE_POS_X, vres: nonzero};
    end

    assign ready_o = !ctrl_reg.valid || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= CTRL_IDLE;
        end else if (ready_o) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            ru_reg <= RW'(un);
            rv_reg <= RW'(vn);
            du_reg <= two_m + four_m;
            dv_reg <= four_m;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign ru_o   = ru_reg;
    assign rv_o   = rv_reg;
    assign du_o   = du_reg;
    assign dv_o   = dv_reg;

endmodule

### hdl/cdau_cell.sv
module cdau_cell
    import cdau_pkg::*;
#(
    parameter int DW = COMPONENT_BITS_DEF + 2,
    parameter int RW = COMPONENT_BITS_DEF + 3,
    parameter int QW = UV_FRACTION_BITS_DEF + 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ctrl_t         ctrl_i,
    output logic          ready_o,
    input  logic [RW-1:0] ru_i,
    input  logic [RW-1:0] rv_i,
    input  logic [DW-1:0] du_i,
    input  logic [DW-1:0] dv_i,
    input  logic [QW-1:0] qu_i,
    input  logic [QW-1:0] qv_i,
    output ctrl_t         ctrl_o,
    input  logic          ready_i,
    output logic [RW-1:0] ru_o,
    output logic [RW-1:0] rv_o,
    output logic [DW-1:0] du_o,
    output logic [DW-1:0] dv_o,
    output logic [QW-1:0] qu_o,
    output logic [QW-1:0] qv_o
);

    // one restoring step per lane: compare, subtract, shift left
    logic          ge_u, ge_v;
    logic [RW-1:0] ru_d, rv_d, ru_next, rv_next;

    ctrl_t         ctrl_reg;
    logic [RW-1:0] ru_reg, rv_reg;
    logic [DW-1:0] du_reg, dv_reg;
    logic [QW-1:0] qu_reg, qv_reg;

    always_comb begin
        ge_u    = ru_i >= RW'(du_i);
        ge_v    = rv_i >= RW'(dv_i);
        ru_d    = ge_u ? (ru_i - RW'(du_i)) : ru_i;
        rv_d    = ge_v ? (rv_i - RW'(dv_i)) : rv_i;
        ru_next = {ru_d[RW-2:0], 1'b0};
        rv_next = {rv_d[RW-2:0], 1'b0};
    end

    assign ready_o = !ctrl_reg.valid || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= CTRL_IDLE;
        end else if (ready_o) begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && ctrl_i.valid) begin
            ru_reg <= ru_next;
            rv_reg <= rv_next;
            du_reg <= du_i;
            dv_reg <= dv_i;
            qu_reg <= {qu_i[QW-2:0], ge_u};
            qv_reg <= {qv_i[QW-2:0], ge_v};
        end
    end

    assign ctrl_o = ctrl_reg;
    assign ru_o   = ru_reg;
    assign rv_o   = rv_reg;
    assign du_o   = du_reg;
    assign dv_o   = dv_reg;
    assign qu_o   = qu_reg;
    assign qv_o   = qv_reg;

endmodule

### hdl/cdau_out.sv
module cdau_out
    import cdau_pkg::*;
#(
    parameter int UV_FRACTION_BITS = UV_FRACTION_BITS_DEF,
    parameter int QW               = UV_FRACTION_BITS_DEF + 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ctrl_t                       ctrl_i,
    output logic                        ready_o,
    input  logic [QW-1:0]               qu_i,
    input  logic [QW-1:0]               qv_i,
    input  logic                        ready_i,
    output logic                        valid_o,
    output logic [UV_FRACTION_BITS:0]   atlas_u_o,
    output logic [UV_FRACTION_BITS:0]   atlas_v_o,
    output face_t                       face_o,
    output logic                        vres_o
);

    // quotient carries one extra bit; (q + 1) >> 1 rounds half up
    logic [QW:0]               sum_u, sum_v;
    logic [UV_FRACTION_BITS:0] u_next, v_next;

    ctrl_t                     ctrl_reg;
    logic [UV_FRACTION_BITS:0] u_reg, v_reg;

    always_comb begin
        sum_u  = {1'b0, qu_i} + (QW + 1)'(1);
        sum_v  = {1'b0, qv_i} + (QW + 1)'(1);
        u_next = ctrl_i.vres ? sum_u[QW-1:1] : '0;
        v_next = ctrl_i.vres ? sum_v[QW-1:1] : '0;
    end

    assign ready_o = !ctrl_reg.valid || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= CTRL_IDLE;
        end else if (ready_o) begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && ctrl_i.valid) begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    assign valid_o   = ctrl_reg.valid;
    assign atlas_u_o = u_reg;
    assign atlas_v_o = v_reg;
    assign face_o    = ctrl_reg.face;
    assign vres_o    = ctrl_reg.vres;

endmodule
